[hdl/frequency_meter_7seg_display_macros.svh]
// assertion macros for the frequency meter rtl
// no dependencies; the including module must have clk and rst in scope
`ifndef FREQUENCY_METER_7SEG_DISPLAY_MACROS_SVH
`define FREQUENCY_METER_7SEG_DISPLAY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define FM7_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FM7_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FM7_ASSERT_IMPL(label, ante, cons, msg)
`define FM7_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/fm7_pkg.sv]
// shared types, constants and the digit font of the frequency meter
// no dependencies
package fm7_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  // decimal digits needed for the widest supported count (65535)
  localparam int BCD_DIGITS          = 5;
  localparam int SCAN_WIDTH          = 3;
  localparam int DIGITS              = 8;

  localparam logic [15:0] GATE_LENGTH_RESET = 16'd800;
  localparam logic [SCAN_WIDTH-1:0] FIRST_SHOWN_POS = 3'd2;
  localparam logic [SCAN_WIDTH-1:0] LAST_POS        = 3'd7;

  localparam logic [7:0] SEG_BLANK = 8'hff;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [BCD_DIGITS-1:0] bcd_word_t;

  typedef struct packed {
    logic inc;    // an edge transfer in this slice
    logic clear;  // a tick closes the gate in this slice
  } count_ctrl_t;

  // active-low font, decimal point dark
  function automatic logic [7:0] seg_digit(input bcd_digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

[hdl/fm7_count.sv]
// edge counter kept in binary and in decimal side by side
// depends on fm7_pkg
module fm7_count #(
  parameter int COUNT_WIDTH = fm7_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fm7_pkg::count_ctrl_t   ctrl,
  output logic [COUNT_WIDTH-1:0] count_edge,
  output fm7_pkg::bcd_word_t     bcd_edge,
  output logic [COUNT_WIDTH-1:0] pulse_count,
  output fm7_pkg::bcd_word_t     pulse_bcd
);
  import fm7_pkg::*;

  logic                   carry;
  logic [COUNT_WIDTH-1:0] pulse_count_next;
  bcd_word_t              pulse_bcd_next;

  assign count_edge = ctrl.inc ? COUNT_WIDTH'(pulse_count + 1'b1) : pulse_count;

  // decimal ripple increment, cleared when the binary counter wraps
  always_comb begin
    bcd_edge = pulse_bcd;
    carry    = ctrl.inc;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (carry) begin
        if (pulse_bcd[i] == 4'd9) begin
          bcd_edge[i] = 4'd0;
        end else begin
          bcd_edge[i] = pulse_bcd[i] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (ctrl.inc && pulse_count == '1) begin
      bcd_edge = '0;
    end
  end

  assign pulse_count_next = ctrl.clear ? '0 : count_edge;
  assign pulse_bcd_next   = ctrl.clear ? '0 : bcd_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      pulse_bcd   <= '0;
    end else begin
      pulse_count <= pulse_count_next;
      pulse_bcd   <= pulse_bcd_next;
    end
  end

endmodule

[hdl/fm7_seg.sv]
// segment pattern for one scanned digit of the held reading
// depends on fm7_pkg
module fm7_seg (
  input  logic [fm7_pkg::SCAN_WIDTH-1:0] scan_pos,
  input  fm7_pkg::bcd_word_t             shown_bcd,
  output logic [7:0]                     seg
);
  import fm7_pkg::*;

  logic [BCD_DIGITS:0]   upper_zero;
  logic [SCAN_WIDTH-1:0] place;

  // upper_zero[k]: every digit from k upward is zero, i.e. value < 10^k
  always_comb begin
    upper_zero[BCD_DIGITS] = 1'b1;
    for (int i = BCD_DIGITS - 1; i >= 0; i--) begin
      upper_zero[i] = upper_zero[i+1] && (shown_bcd[i] == 4'd0);
    end
  end

  assign place = LAST_POS - scan_pos;

  always_comb begin
    priority if (scan_pos < FIRST_SHOWN_POS) begin
      seg = SEG_BLANK;
    end else if (32'(place) >= BCD_DIGITS) begin
      seg = SEG_BLANK;
    end else if (scan_pos != LAST_POS && upper_zero[place]) begin
      seg = SEG_BLANK;
    end else begin
      seg = seg_digit(shown_bcd[place]);
    end
  end

endmodule

[hdl/frequency_meter_7seg_display.sv]
// Gate-time frequency meter driving an eight-digit multiplexed seven-segment
// display. Each transfer on the input is one clock slice carrying an edge flag
// and a tick flag; a slice with tick set yields one result, a scan step with
// the one-hot digit enable, the active-low segment byte, the held reading and
// a flag for a gate that closed on that tick. One slice is taken every clock;
// results go out through a one-deep output register the cycle after the slice,
// and input stalls only while that register holds a result the sink stalls.
// The count is kept in decimal alongside binary, so no conversion stands in
// the path. gate_length is written through gate_length_we/gate_length_wdata.
// depends on fm7_pkg, fm7_count, fm7_seg and the macros header
module frequency_meter_7seg_display #(
  parameter int COUNT_WIDTH = fm7_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        gate_length_we,
  input  logic [15:0] gate_length_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        edge_seen,
  input  logic        tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  digit_select,
  output logic [7:0]  segments,
  output logic [15:0] frequency,
  output logic        new_reading
);
  import fm7_pkg::*;

  `include "frequency_meter_7seg_display_macros.svh"

  logic [15:0]            gate_length;
  logic [15:0]            gate_ticks;
  logic [15:0]            gate_ticks_inc;
  logic                   gate_close;
  logic [COUNT_WIDTH-1:0] shown_frequency;
  bcd_word_t              shown_bcd;
  logic [SCAN_WIDTH-1:0]  scan_index;
  logic                   accept;
  logic                   tick_accept;
  count_ctrl_t            ctrl;
  logic [COUNT_WIDTH-1:0] count_edge;
  bcd_word_t              bcd_edge;
  logic [COUNT_WIDTH-1:0] pulse_count;
  bcd_word_t              pulse_bcd;
  logic [7:0]             seg_out;

  assign in_stall    = out_valid && out_stall;
  assign accept      = in_valid && !in_stall;
  assign tick_accept = accept && tick;

  assign gate_ticks_inc = gate_ticks + 16'd1;
  assign gate_close     = gate_ticks_inc >= gate_length;

  assign ctrl.inc   = accept && edge_seen;
  assign ctrl.clear = tick_accept && gate_close;

  fm7_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .count_edge  (count_edge),
    .bcd_edge    (bcd_edge),
    .pulse_count (pulse_count),
    .pulse_bcd   (pulse_bcd)
  );

  fm7_seg u_seg (
    .scan_pos  (scan_index),
    .shown_bcd (shown_bcd),
    .seg       (seg_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_length     <= GATE_LENGTH_RESET;
      gate_ticks      <= '0;
      shown_frequency <= '0;
      shown_bcd       <= '0;
      scan_index      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (gate_length_we) begin
        gate_length <= gate_length_wdata;
      end
      if (tick_accept) begin
        gate_ticks <= gate_close ? 16'd0 : gate_ticks_inc;
        scan_index <= scan_index + 1'b1;
      end
      if (ctrl.clear) begin
        shown_frequency <= count_edge;
        shown_bcd       <= bcd_edge;
      end
      if (tick_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each tick transfer
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      digit_select <= 8'd1 << scan_index;
      segments     <= seg_out;
      frequency    <= ctrl.clear ? 16'(count_edge) : 16'(shown_frequency);
      new_reading  <= gate_close;
    end
  end

  `FM7_ASSERT_IMPL(a_digit_onehot, out_valid, $onehot(digit_select), "digit_select not one-hot")
  `FM7_ASSERT_IMPL(a_stall_only_full, in_stall, out_valid, "input stalled with empty output")
  `FM7_ASSERT_NEXT(a_gate_restart, ctrl.clear, pulse_count == '0 && gate_ticks == 16'd0, "gate close did not restart counters")
  `FM7_ASSERT_IMPL(a_ticks_bound, 1'b1, gate_ticks != 16'hffff, "gate tick counter overran")
  `FM7_ASSERT_IMPL(a_bcd_digits, 1'b1, pulse_bcd[0] < 4'd10 && pulse_bcd[1] < 4'd10 && pulse_bcd[2] < 4'd10 && pulse_bcd[3] < 4'd10 && pulse_bcd[4] < 4'd10, "decimal counter digit out of range")

endmodule
